// ===== rtl/crc8fr_pkg.sv =====
`timescale 1ns / 1ps

package crc8fr_pkg;

  // Frame format constants.
  localparam logic [7:0] SYNC_A   = 8'hAA;
  localparam logic [7:0] SYNC_B   = 8'hBB;
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Default payload store depth and reset value of the payload limit register.
  localparam int         MAX_PAYLOAD_DEF = 27;
  localparam logic [4:0] MAX_PAYLOAD_RST = 5'd27;

  // Kind of result word.
  typedef enum logic [1:0] {
    EV_DATA = 2'd0,
    EV_ACK  = 2'd1,
    EV_ERR  = 2'd2
  } event_t;

  // Error code carried with each result word.
  typedef enum logic [1:0] {
    ERR_HEADER = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_CRC    = 2'd2,
    ERR_NONE   = 2'd3
  } err_t;

endpackage

// ===== rtl/crc8_frame_receiver.sv =====
`timescale 1ns / 1ps

// Frame receiver for a byte-serial link. Each input word is one received byte;
// frames are AA BB, seq, len, payload[len], CRC-8 (poly 0x31, init 0xFF, MSB
// first) over seq, len and payload. A good frame produces an ack word carrying
// the sequence number followed by its payload words; a repeated sequence number
// produces only the ack and the rest of that frame is dropped. Header, length
// and CRC faults each produce one error word. Timing: a byte that feeds the CRC
// (seq, and the len and payload of a frame being received) holds s_tready low
// while the CRC is updated one bit per clock. Header, skipped and CRC bytes,
// and the len byte of a repeated or oversize frame, do not feed the CRC; they
// hold s_tready low only while they produce an error or ack word. After a good
// CRC byte the ack and payload are drained from the payload memory, with s_tready
// low, through a registered memory read, and the drain stalls while m_tready is
// held low. The length limit taken from the max_payload register is clamped to
// MAX_PAYLOAD.
module crc8_frame_receiver
  import crc8fr_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // Configuration: payload length limit.
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  // Received byte stream.
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // [7:0] rx_byte
  // Result stream.
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [7:0] out_byte
  output logic [3:0] m_tuser,    // [1:0] event_res, [3:2] error_code
  output logic       m_tlast     // last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  typedef enum logic [2:0] {
    PH_HUNT, PH_SYNC2, PH_SEQ, PH_LEN, PH_DATA, PH_CRC, PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    C_IDLE, C_SHIFT, C_RESULT, C_DRAIN
  } ctrl_t;

  ctrl_t           ctrl;
  phase_t          phase;
  logic [7:0]      last_seq;
  logic            dup_flag;
  logic [7:0]      frame_len;
  logic [8:0]      byte_count;
  logic [7:0]      crc_acc;
  logic [2:0]      bit_cnt;
  logic [4:0]      max_payload;
  event_t          pend_event;
  err_t            pend_err;
  logic [7:0]      pend_byte;
  logic [AW-1:0]   rd_addr;
  logic            rd_fresh;
  logic            ack_sent;
  logic [7:0]      mem_rdata;
  logic [7:0]      mem [MAX_PAYLOAD];

  logic            in_accept;
  logic            out_free;
  logic            out_load;
  logic [7:0]      bound;
  logic [8:0]      byte_count_inc;
  logic            drain_last;
  logic [7:0]      crc_shl;

  // Handshake and small helpers.
  assign s_tready       = (ctrl == C_IDLE);
  assign in_accept      = s_tvalid && s_tready;
  assign out_free       = !m_tvalid || m_tready;
  assign out_load       = out_free && ((ctrl == C_RESULT) ||
                                       ((ctrl == C_DRAIN) && (!ack_sent || rd_fresh)));
  assign bound          = (8'(max_payload) > 8'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD)
                                                             : 8'(max_payload);
  assign byte_count_inc = byte_count + 9'd1;
  assign drain_last     = (9'(rd_addr) + 9'd1) == {1'b0, frame_len};
  assign crc_shl        = {crc_acc[6:0], 1'b0};

  // Payload memory: written while the frame arrives, read during the drain.
  always_ff @(posedge clk) begin
    if (in_accept && (phase == PH_DATA)) begin
      mem[byte_count[AW-1:0]] <= s_tdata;
    end
    mem_rdata <= mem[rd_addr];
  end

  // Frame parser, serial CRC and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl        <= C_IDLE;
      phase       <= PH_HUNT;
      last_seq    <= 8'd0;
      dup_flag    <= 1'b0;
      frame_len   <= 8'd0;
      byte_count  <= 9'd0;
      crc_acc     <= CRC_INIT;
      bit_cnt     <= 3'd0;
      max_payload <= MAX_PAYLOAD_RST;
      m_tvalid    <= 1'b0;
      rd_fresh    <= 1'b0;
      ack_sent    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_payload <= cfg_wr_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (ctrl)
        C_IDLE: begin
          if (in_accept) begin
            case (phase)
              PH_HUNT: begin
                if (s_tdata == SYNC_A) begin
                  phase <= PH_SYNC2;
                end else begin
                  pend_event <= EV_ERR;
                  pend_err   <= ERR_HEADER;
                  pend_byte  <= 8'd0;
                  ctrl       <= C_RESULT;
                end
              end
              PH_SYNC2: begin
                if (s_tdata == SYNC_B) begin
                  phase <= PH_SEQ;
                end else begin
                  pend_event <= EV_ERR;
                  pend_err   <= ERR_HEADER;
                  pend_byte  <= 8'd0;
                  ctrl       <= C_RESULT;
                  phase      <= PH_HUNT;
                end
              end
              PH_SEQ: begin
                crc_acc <= CRC_INIT ^ s_tdata;
                bit_cnt <= 3'd0;
                ctrl    <= C_SHIFT;
                if (s_tdata == last_seq) begin
                  dup_flag <= 1'b1;
                end else begin
                  dup_flag <= 1'b0;
                  last_seq <= s_tdata;
                end
                phase <= PH_LEN;
              end
              PH_LEN: begin
                frame_len  <= s_tdata;
                byte_count <= 9'd0;
                if (dup_flag) begin
                  // Repeated frame: ack now, then drop len+1 bytes.
                  pend_event <= EV_ACK;
                  pend_err   <= ERR_NONE;
                  pend_byte  <= last_seq;
                  ctrl       <= C_RESULT;
                  byte_count <= {1'b0, s_tdata} + 9'd1;
                  phase      <= PH_SKIP;
                end else if (s_tdata > bound) begin
                  pend_event <= EV_ERR;
                  pend_err   <= ERR_LENGTH;
                  pend_byte  <= 8'd0;
                  ctrl       <= C_RESULT;
                  phase      <= PH_HUNT;
                end else begin
                  crc_acc <= crc_acc ^ s_tdata;
                  bit_cnt <= 3'd0;
                  ctrl    <= C_SHIFT;
                  phase   <= (s_tdata == 8'd0) ? PH_CRC : PH_DATA;
                end
              end
              PH_DATA: begin
                crc_acc    <= crc_acc ^ s_tdata;
                bit_cnt    <= 3'd0;
                ctrl       <= C_SHIFT;
                byte_count <= byte_count_inc;
                if (byte_count_inc >= {1'b0, frame_len}) begin
                  phase <= PH_CRC;
                end
              end
              PH_CRC: begin
                if (s_tdata != crc_acc) begin
                  pend_event <= EV_ERR;
                  pend_err   <= ERR_CRC;
                  pend_byte  <= 8'd0;
                  ctrl       <= C_RESULT;
                end else begin
                  ack_sent <= 1'b0;
                  rd_addr  <= '0;
                  rd_fresh <= 1'b0;
                  ctrl     <= C_DRAIN;
                end
                phase <= PH_HUNT;
              end
              PH_SKIP: begin
                if (byte_count <= 9'd1) begin
                  byte_count <= 9'd0;
                  phase      <= PH_HUNT;
                end else begin
                  byte_count <= byte_count - 9'd1;
                end
              end
              default: begin
                phase <= PH_HUNT;
              end
            endcase
          end
        end

        // One CRC bit per clock, MSB first.
        C_SHIFT: begin
          crc_acc <= crc_acc[7] ? (crc_shl ^ CRC_POLY) : crc_shl;
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            ctrl <= C_IDLE;
          end
        end

        // A single error or ack word waits for the output register.
        C_RESULT: begin
          if (out_free) begin
            m_tdata  <= pend_byte;
            m_tuser  <= {pend_err, pend_event};
            m_tlast  <= 1'b1;
            ctrl     <= C_IDLE;
          end
        end

        // Ack then payload words of a good frame. The read data is fresh in the
        // cycle after the read address last moved.
        C_DRAIN: begin
          if (out_free) begin
            if (!ack_sent) begin
              m_tdata  <= last_seq;
              m_tuser  <= {ERR_NONE, EV_ACK};
              m_tlast  <= (frame_len == 8'd0);
              ack_sent <= 1'b1;
              rd_fresh <= 1'b1;
              if (frame_len == 8'd0) begin
                ctrl <= C_IDLE;
              end
            end else if (rd_fresh) begin
              m_tdata  <= mem_rdata;
              m_tuser  <= {ERR_NONE, EV_DATA};
              m_tlast  <= drain_last;
              if (drain_last) begin
                ctrl <= C_IDLE;
              end else begin
                rd_addr  <= rd_addr + AW'(1);
                rd_fresh <= 1'b0;
              end
            end else begin
              rd_fresh <= 1'b1;
            end
          end else begin
            rd_fresh <= 1'b1;
          end
        end

        default: begin
          ctrl <= C_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/crc8fr_checker.sv =====
`timescale 1ns / 1ps

module crc8fr_checker
  import crc8fr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [3:0] m_tuser,
  input logic       m_tlast
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word present after reset");

  // An error word carries a zero byte and ends the results of its byte.
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[1:0] == EV_ERR)) |-> ((m_tdata == 8'd0) && m_tlast))
    else $error("malformed error word");

  // Ack and payload words carry no error code.
  a_ok_code: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((m_tuser[1:0] == EV_ACK) || (m_tuser[1:0] == EV_DATA)))
      |-> (m_tuser[3:2] == ERR_NONE))
    else $error("ack or payload word with an error code");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast)))
    else $error("stalled result word changed");

endmodule

bind crc8_frame_receiver crc8fr_checker u_crc8fr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== tb/sv/crc8_frame_receiver_chk.sv =====
`timescale 1ns / 1ps

// Watches both streams of the frame receiver, keeps its own copy of the
// parser state and the payload limit, and compares every result word with the
// oldest one it predicted.
module crc8_frame_receiver_chk
  import crc8fr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,    // [7:0] rx_byte
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,    // [7:0] out_byte
  input  logic [3:0] m_tuser,    // [1:0] event_res, [3:2] error_code
  input  logic       m_tlast,
  output int         fail_count,
  output int         words_due
);

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_SYNC2,
    ST_SEQ,
    ST_LEN,
    ST_DATA,
    ST_CRC,
    ST_SKIP
  } parse_state_t;

  typedef struct packed {
    event_t     kind;
    logic [7:0] data;
    err_t       code;
    logic       last;
  } result_word_t;

  // Reports stop after this many so that a badly broken design keeps the log short.
  localparam int REPORT_LIMIT = 100;

  result_word_t awaited_words[$];
  parse_state_t parse_state;
  logic [4:0]   payload_limit;
  logic [7:0]   last_seq;
  logic [7:0]   frame_len;
  logic [7:0]   crc_acc;
  logic         dup_frame;
  logic [8:0]   byte_count;
  logic [7:0]   payload_mem [MAX_PAYLOAD_DEF];
  int           errors = 0;

  // One byte through the CRC-8, most significant bit first.
  function automatic logic [7:0] crc8_update(logic [7:0] acc, logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  task automatic queue_word(event_t kind, logic [7:0] data, err_t code, logic last);
    awaited_words.push_back('{kind, data, code, last});
  endtask

  task automatic compare_field(string field, logic [7:0] expv, logic [7:0] actv);
    if (actv !== expv) begin
      errors++;
      if (errors <= REPORT_LIMIT) begin
        $error("%s mismatch: expected %0d, actual %0d", field, expv, actv);
      end
    end
  endtask

  // Advances the parser by one received byte and queues the words it causes.
  task automatic parse_rx_byte(logic [7:0] b);
    int bound;
    int cnt;
    bound = (payload_limit > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : payload_limit;
    case (parse_state)
      ST_HUNT: begin
        if (b == SYNC_A) begin
          parse_state = ST_SYNC2;
        end else begin
          queue_word(EV_ERR, 8'h00, ERR_HEADER, 1'b1);
        end
      end
      ST_SYNC2: begin
        if (b == SYNC_B) begin
          parse_state = ST_SEQ;
        end else begin
          queue_word(EV_ERR, 8'h00, ERR_HEADER, 1'b1);
          parse_state = ST_HUNT;
        end
      end
      ST_SEQ: begin
        // The new number is stored at once, before the length is known.
        crc_acc     = crc8_update(CRC_INIT, b);
        dup_frame   = (b == last_seq);
        last_seq    = b;
        parse_state = ST_LEN;
      end
      ST_LEN: begin
        crc_acc    = crc8_update(crc_acc, b);
        frame_len  = b;
        byte_count = '0;
        if (dup_frame) begin
          // A repeat is acked at once; payload and CRC are then dropped.
          queue_word(EV_ACK, last_seq, ERR_NONE, 1'b1);
          byte_count  = {1'b0, b} + 9'd1;
          parse_state = ST_SKIP;
        end else if (b > bound) begin
          queue_word(EV_ERR, 8'h00, ERR_LENGTH, 1'b1);
          parse_state = ST_HUNT;
        end else begin
          parse_state = (b == 8'd0) ? ST_CRC : ST_DATA;
        end
      end
      ST_DATA: begin
        crc_acc = crc8_update(crc_acc, b);
        if (byte_count < MAX_PAYLOAD_DEF) begin
          payload_mem[byte_count] = b;
        end
        byte_count = byte_count + 9'd1;
        if (byte_count >= frame_len) begin
          parse_state = ST_CRC;
        end
      end
      ST_CRC: begin
        if (b != crc_acc) begin
          queue_word(EV_ERR, 8'h00, ERR_CRC, 1'b1);
        end else begin
          cnt = (frame_len > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : frame_len;
          queue_word(EV_ACK, last_seq, ERR_NONE, cnt == 0);
          for (int i = 0; i < cnt; i++) begin
            queue_word(EV_DATA, payload_mem[i], ERR_NONE, i == cnt - 1);
          end
        end
        parse_state = ST_HUNT;
      end
      ST_SKIP: begin
        if (byte_count > 0) begin
          byte_count = byte_count - 9'd1;
        end
        if (byte_count == 0) begin
          parse_state = ST_HUNT;
        end
      end
      default: begin
        parse_state = ST_HUNT;
      end
    endcase
  endtask

  // Result words are checked before the byte taken at the same edge is parsed,
  // since a byte's words can only appear after it was accepted.
  always @(posedge clk) begin
    result_word_t head;
    if (rst) begin
      parse_state   = ST_HUNT;
      payload_limit = MAX_PAYLOAD_RST;
      last_seq      = '0;
      frame_len     = '0;
      crc_acc       = CRC_INIT;
      dup_frame     = 1'b0;
      byte_count    = '0;
      for (int i = 0; i < MAX_PAYLOAD_DEF; i++) begin
        payload_mem[i] = '0;
      end
      awaited_words.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_words.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $error("result word with none expected: tdata %0d, tuser %0d, tlast %0d",
                   m_tdata, m_tuser, m_tlast);
          end
        end else begin
          head = awaited_words.pop_front();
          compare_field("event_res", head.kind, m_tuser[1:0]);
          compare_field("out_byte", head.data, m_tdata);
          compare_field("error_code", head.code, m_tuser[3:2]);
          compare_field("last", head.last, m_tlast);
        end
      end
      if (cfg_wr_en) begin
        payload_limit = cfg_wr_data;
      end
      if (s_tvalid && s_tready) begin
        parse_rx_byte(s_tdata);
      end
    end
    fail_count <= errors;
    words_due  <= awaited_words.size();
  end

endmodule

// ===== tb/sv/crc8_frame_receiver_tb.sv =====
`timescale 1ns / 1ps

module crc8_frame_receiver_tb;
  import crc8fr_pkg::*;

  // Cycles without any accepted word before the run is declared hung.
  localparam int STALL_LIMIT = 1000;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       cfg_wr_en   = 1'b0;
  logic [4:0] cfg_wr_data = '0;
  logic       s_tvalid    = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata     = '0;
  logic       m_tvalid;
  logic       m_tready    = 1'b0;
  logic [7:0] m_tdata;
  logic [3:0] m_tuser;
  logic       m_tlast;

  int         fail_count;
  int         words_due;
  int         quiet_cycles    = 0;
  int         ready_hold      = 0;
  int         ready_stall_pct = 0;
  bit         sender_burst    = 1'b0;
  int         bytes_sent      = 0;
  int         payload_bound   = MAX_PAYLOAD_DEF;
  logic [7:0] prev_seq        = 8'h00;

  crc8_frame_receiver u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  crc8_frame_receiver_chk u_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Idle length: none half the time, otherwise mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 50) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 10);
  endfunction

  // Payload and noise bytes lean toward sync bytes and the extremes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9, 0))
      0:       return SYNC_A;
      1:       return SYNC_B;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  // A sequence number that differs from the one sent last.
  function automatic logic [7:0] fresh_seq();
    logic [7:0] s;
    do begin
      s = 8'($urandom());
    end while (s == prev_seq);
    return s;
  endfunction

  // Mostly short payloads, some up to the bound and a few at the bound.
  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(99, 0);
    if (r < 55) begin
      return 8'($urandom_range((payload_bound < 3) ? payload_bound : 3, 0));
    end else if (r < 90) begin
      return 8'($urandom_range(payload_bound, 0));
    end
    return 8'(payload_bound);
  endfunction

  function automatic logic [7:0] crc8_next(logic [7:0] acc, logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  // Result side: ready with random stalls of random length.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(99, 0) < ready_stall_pct) begin
        ready_hold <= 1 + pick_gap();
      end
    end
  end

  // Watchdog on accepted words of either stream.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** crc8_frame_receiver: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one byte after an optional gap and waits until it is taken.
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = sender_burst ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(logic [7:0] seq, logic [7:0] len, bit corrupt_crc);
    logic [7:0] crc;
    logic [7:0] pb;
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    send_byte(seq);
    send_byte(len);
    crc = crc8_next(crc8_next(CRC_INIT, seq), len);
    for (int i = 0; i < len; i++) begin
      pb  = pick_byte();
      crc = crc8_next(crc, pb);
      send_byte(pb);
    end
    if (corrupt_crc) begin
      crc = crc ^ 8'($urandom_range(255, 1));
    end
    send_byte(crc);
    prev_seq = seq;
  endtask

  // Header with a length the parser must refuse; nothing follows it.
  task automatic send_oversize(logic [7:0] seq, logic [7:0] len);
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    send_byte(seq);
    send_byte(len);
    prev_seq = seq;
  endtask

  // Stops the sender until every predicted word has come out, then lets a
  // byte that is still in the CRC loop finish.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (24) @(posedge clk);
  endtask

  // Mostly well-formed frames, with repeats, refused lengths, bad CRCs and noise.
  task automatic random_traffic(int quota);
    int         stop_at;
    int         r;
    logic [7:0] len;
    stop_at = bytes_sent + quota;
    while (bytes_sent < stop_at) begin
      sender_burst = ($urandom_range(99, 0) < 20);
      r = $urandom_range(99, 0);
      if (r < 62) begin
        send_frame(fresh_seq(), pick_len(), 1'b0);
      end else if (r < 72) begin
        len = ($urandom_range(3, 0) == 0) ? 8'($urandom_range(60, 20))
                                          : 8'($urandom_range(6, 0));
        send_frame(prev_seq, len, $urandom_range(1, 0));
      end else if (r < 80) begin
        len = $urandom_range(1, 0) ? 8'(payload_bound + 1)
                                   : 8'($urandom_range(255, payload_bound + 1));
        send_oversize(fresh_seq(), len);
      end else if (r < 88) begin
        send_frame(fresh_seq(), pick_len(), 1'b1);
      end else begin
        if ($urandom_range(1, 0)) begin
          send_byte(SYNC_A);
        end
        repeat ($urandom_range(3, 1)) send_byte(pick_byte());
      end
    end
  endtask

  initial begin
    int         phase_limit [5];
    int         phase_quota [5];
    int         phase_stall [5];
    logic [4:0] new_limit;
    phase_limit = '{31, 0, 5, 0, 27};
    phase_quota = '{110, 50, 90, 80, 80};
    phase_stall = '{25, 0, 50, 10, 35};
    phase_limit[3] = $urandom_range(26, 6);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run at the reset value of the payload limit.
    ready_stall_pct = 20;
    send_byte(8'h00);                 // bad first header byte
    send_byte(SYNC_A);
    send_byte(8'hFF);                 // bad second header byte
    send_frame(8'h00, 8'd0, 1'b0);    // seq 0 right after reset is a repeat
    send_frame(8'h01, 8'd0, 1'b0);    // zero length: ack alone, marked last
    send_oversize(8'h02, 8'd28);      // one past the largest payload
    send_frame(8'h03, 8'd0, 1'b1);    // CRC mismatch
    send_frame(8'h04, 8'd1, 1'b0);    // ack followed by one payload word

    // Random phases, each under its own payload limit and stall rate.
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      new_limit   = 5'(phase_limit[p]);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= new_limit;
      @(posedge clk);
      cfg_wr_en     <= 1'b0;
      payload_bound = (new_limit > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : new_limit;
      ready_stall_pct = phase_stall[p];
      random_traffic(phase_quota[p]);
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("** crc8_frame_receiver: PASSED **");
    end else begin
      $display("** crc8_frame_receiver: FAILED **");
    end
    $finish;
  end

endmodule
